FILE: src/dbsu_pkg.sv
// ----------------------------------------------------------------------------
// dbsu_pkg
// Shared types and constants for the debug breakpoint and step unit.
// ----------------------------------------------------------------------------
package dbsu_pkg;

    typedef enum logic [3:0] {
        ACT_EXEC        = 4'd0,
        ACT_RECHECK     = 4'd1,
        ACT_RUN         = 4'd2,
        ACT_STOP        = 4'd3,
        ACT_STEP_IN     = 4'd4,
        ACT_STEP_OVER   = 4'd5,
        ACT_STEP_OUT    = 4'd6,
        ACT_ADD         = 4'd7,
        ACT_REMOVE      = 4'd8,
        ACT_CLEAR       = 4'd9,
        ACT_EXCP_MODE   = 4'd10,
        ACT_EXCEPTION   = 4'd11,
        ACT_READ_STATUS = 4'd12,
        ACT_DONE        = 4'd13
    } action_t;

    typedef enum logic [1:0] {
        RESP_OK   = 2'd0,
        RESP_FAIL = 2'd1,
        RESP_BUSY = 2'd2
    } resp_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_SCAN_RD  = 6'b000010,
        ST_SCAN_CMP = 6'b000100,
        ST_MV_RD    = 6'b001000,
        ST_MV_WR    = 6'b010000,
        ST_FIN      = 6'b100000
    } state_t;

    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] method;
    } bkp_entry_t;

    // status byte bits
    localparam logic [7:0] STS_STOP     = 8'h01;
    localparam logic [7:0] STS_STOP_SET = 8'h02;
    localparam logic [7:0] STS_STEP_IN  = 8'h04;
    localparam logic [7:0] STS_STEP_OV  = 8'h08;
    localparam logic [7:0] STS_STEP_OUT = 8'h10;
    localparam logic [7:0] STS_EXCP     = 8'h20;
    localparam logic [7:0] STS_EXCP_EN  = 8'h40;
    localparam logic [7:0] STS_DONE     = 8'h80;
    localparam logic [7:0] STS_STEPS    = STS_STEP_IN | STS_STEP_OV | STS_STEP_OUT;
    localparam logic [7:0] STS_RESET    = STS_STOP;

endpackage

FILE: src/debug_breakpoint_step_unit.sv
// ----------------------------------------------------------------------------
// debug_breakpoint_step_unit
// Debug halt unit: breakpoint table, status byte and single-step tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one word per executed
//   instruction, recheck, core exception or debugger command. Output channel
//   (out_valid / out_stall) returns one word per input: halt, resp_code and
//   status_byte.
//   The breakpoint table is a small memory scanned one entry at a time, with
//   a read state and a compare state per entry, by a single (method, pc)
//   comparator under the sequencer. A scan ends at the first hit or after
//   all n entries; a remove that hits entry k then moves the last entry
//   into its place through a move read and a move write state. Exec scans
//   only while not stopped; add scans while the table is not full, remove
//   while it is not empty.
//   One item is in work at a time; in_stall stays high until the result is
//   loaded into the output register, so the next word is taken while the
//   previous result still waits there.
//   If out_stall holds the output register full, the sequencer waits in its
//   final state and state is committed only when the result is loaded.
//   Reset: status reads stop only, table empty, step bound zero; table
//   entries and the step start point hold no defined value until written.
// ----------------------------------------------------------------------------
module debug_breakpoint_step_unit #(
    parameter int MAX_BREAKPOINTS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [3:0]  action,
    input  logic [31:0] pc,
    input  logic [31:0] method_id,
    input  logic [31:0] stack_ptr,
    input  logic [31:0] step_length,
    input  logic        enable_bit,
    input  logic        frame_valid,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        halt,
    output logic [1:0]  resp_code,
    output logic [7:0]  status_byte
);

    localparam int CNT_W = $clog2(MAX_BREAKPOINTS + 1);
    localparam int IDX_W = (MAX_BREAKPOINTS > 1) ? $clog2(MAX_BREAKPOINTS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BREAKPOINTS);

    dbsu_pkg::state_t state_reg, state_next;

    // captured item
    logic [3:0]  act_reg;
    logic [31:0] pc_reg;
    logic [31:0] mid_reg;
    logic [31:0] sp_reg;
    logic [31:0] len_reg;
    logic        en_reg;
    logic        fv_reg;

    logic [7:0]       status_reg, status_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             hit_reg, hit_next;
    logic [31:0]      start_pc_reg, start_sp_reg, start_mid_reg;
    logic [31:0]      bound_reg;

    logic        out_valid_reg, out_valid_next;
    logic        halt_reg;
    logic [1:0]  resp_reg;
    logic [7:0]  sts_out_reg;

    // breakpoint memory
    dbsu_pkg::bkp_entry_t mem [MAX_BREAKPOINTS];
    dbsu_pkg::bkp_entry_t rd_reg;
    dbsu_pkg::bkp_entry_t wr_data;
    logic [IDX_W-1:0]     rd_addr, wr_addr;
    logic                 wr_en;

    logic             accept;
    logic             out_free;
    logic             commit;
    logic             need_scan;
    logic             entry_match;
    logic [CNT_W-1:0] cnt_last;

    // finish-state results
    logic [7:0]  f;
    logic [7:0]  f2;
    logic [7:0]  shown;
    logic [7:0]  step_bit;
    logic        run_rule;
    logic        halt_v;
    logic [1:0]  resp_v;
    logic        load_start;
    logic        load_bound;
    logic        ended;
    logic        left_rng;
    logic [31:0] pc_diff;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != dbsu_pkg::ST_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign commit   = (state_reg == dbsu_pkg::ST_FIN) && out_free;
    assign cnt_last = cnt_reg - CNT_W'(1);

    assign entry_match = (rd_reg.method == mid_reg) && (rd_reg.pc == pc_reg);

    always_comb
    begin
        need_scan = 1'b0;
        case (action)
            dbsu_pkg::ACT_EXEC:   need_scan = !status_reg[0];
            dbsu_pkg::ACT_ADD:    need_scan = (cnt_reg < CNT_MAX);
            dbsu_pkg::ACT_REMOVE: need_scan = (cnt_reg != '0);
            default:              need_scan = 1'b0;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        hit_next     = hit_reg;
        hit_idx_next = hit_idx_reg;
        rd_addr      = idx_reg[IDX_W-1:0];
        case (state_reg)
            dbsu_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    hit_next   = 1'b0;
                    state_next = need_scan ? dbsu_pkg::ST_SCAN_RD : dbsu_pkg::ST_FIN;
                end
            end
            dbsu_pkg::ST_SCAN_RD:
            begin
                if (idx_reg == cnt_reg)
                    state_next = dbsu_pkg::ST_FIN;
                else
                    state_next = dbsu_pkg::ST_SCAN_CMP;
            end
            dbsu_pkg::ST_SCAN_CMP:
            begin
                if (entry_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = idx_reg[IDX_W-1:0];
                    state_next   = (act_reg == dbsu_pkg::ACT_REMOVE) ?
                                   dbsu_pkg::ST_MV_RD : dbsu_pkg::ST_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = dbsu_pkg::ST_SCAN_RD;
                end
            end
            dbsu_pkg::ST_MV_RD:
            begin
                rd_addr    = cnt_last[IDX_W-1:0];
                state_next = dbsu_pkg::ST_MV_WR;
            end
            dbsu_pkg::ST_MV_WR:
            begin
                state_next = dbsu_pkg::ST_FIN;
            end
            dbsu_pkg::ST_FIN:
            begin
                if (out_free)
                    state_next = dbsu_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dbsu_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------- finish: command decode and halt rule ----------------
    always_comb
    begin
        f          = status_reg;
        f2         = status_reg;
        shown      = status_reg;
        step_bit   = '0;
        run_rule   = 1'b0;
        halt_v     = 1'b0;
        resp_v     = dbsu_pkg::RESP_OK;
        load_start = 1'b0;
        load_bound = 1'b0;
        cnt_next   = cnt_reg;

        case (act_reg)
            dbsu_pkg::ACT_EXEC:
            begin
                if (hit_reg)
                    f = f | dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET;
                run_rule = 1'b1;
            end
            dbsu_pkg::ACT_RECHECK:
            begin
                run_rule = 1'b1;
            end
            dbsu_pkg::ACT_RUN:
            begin
                f = f & ~(dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET |
                          dbsu_pkg::STS_STEPS | dbsu_pkg::STS_EXCP);
            end
            dbsu_pkg::ACT_STOP:
            begin
                f = (f & ~(dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_STEPS |
                           dbsu_pkg::STS_EXCP)) | dbsu_pkg::STS_STOP;
            end
            dbsu_pkg::ACT_STEP_IN, dbsu_pkg::ACT_STEP_OVER, dbsu_pkg::ACT_STEP_OUT:
            begin
                if (!status_reg[0] ||
                    (act_reg != dbsu_pkg::ACT_STEP_OUT && len_reg == '0))
                    resp_v = dbsu_pkg::RESP_BUSY;
                else if (!fv_reg)
                    resp_v = dbsu_pkg::RESP_FAIL;
                else
                begin
                    load_start = 1'b1;
                    load_bound = (act_reg != dbsu_pkg::ACT_STEP_OUT);
                    if (act_reg == dbsu_pkg::ACT_STEP_IN)
                        step_bit = dbsu_pkg::STS_STEP_IN;
                    else if (act_reg == dbsu_pkg::ACT_STEP_OVER)
                        step_bit = dbsu_pkg::STS_STEP_OV;
                    else
                        step_bit = dbsu_pkg::STS_STEP_OUT;
                    f = (f & ~(dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_STEPS |
                               dbsu_pkg::STS_EXCP)) | step_bit;
                end
            end
            dbsu_pkg::ACT_ADD:
            begin
                if (cnt_reg >= CNT_MAX)
                    resp_v = dbsu_pkg::RESP_FAIL;
                else if (!hit_reg)
                    cnt_next = cnt_reg + CNT_W'(1);
            end
            dbsu_pkg::ACT_REMOVE:
            begin
                if (cnt_reg == '0)
                    resp_v = dbsu_pkg::RESP_FAIL;
                else if (hit_reg)
                    cnt_next = cnt_last;
            end
            dbsu_pkg::ACT_CLEAR:
            begin
                cnt_next = '0;
            end
            dbsu_pkg::ACT_EXCP_MODE:
            begin
                if (en_reg)
                    f = f | dbsu_pkg::STS_EXCP_EN;
                else
                    f = f & ~dbsu_pkg::STS_EXCP_EN;
            end
            dbsu_pkg::ACT_EXCEPTION:
            begin
                // stop is set here and an exception starts no scan, so the breakpoint test never fires
                f = (f & ~dbsu_pkg::STS_STEPS) | dbsu_pkg::STS_STOP |
                    dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_EXCP;
                run_rule = 1'b1;
            end
            dbsu_pkg::ACT_READ_STATUS:
            begin
                if ((status_reg & dbsu_pkg::STS_STEPS) != '0)
                    shown = status_reg & ~(dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_STOP);
                if (shown[1])
                    f = f & ~dbsu_pkg::STS_STOP_SET;
            end
            dbsu_pkg::ACT_DONE:
            begin
                f = f | dbsu_pkg::STS_DONE;
            end
            default:
            begin
                resp_v = dbsu_pkg::RESP_FAIL;
            end
        endcase

        // step range check against the stored start point
        pc_diff  = pc_reg - start_pc_reg;
        left_rng = (mid_reg != start_mid_reg) || (pc_diff >= bound_reg) ||
                   (pc_reg <= start_pc_reg);
        if (f[2])
        begin
            step_bit = dbsu_pkg::STS_STEP_IN;
            ended    = left_rng;
        end
        else if (f[3])
        begin
            step_bit = dbsu_pkg::STS_STEP_OV;
            ended    = (sp_reg <= start_sp_reg) && left_rng;
        end
        else
        begin
            step_bit = dbsu_pkg::STS_STEP_OUT;
            ended    = (sp_reg < start_sp_reg);
        end

        if (run_rule)
        begin
            if ((f & dbsu_pkg::STS_STEPS) == '0)
                halt_v = f[0] || f[5];
            else if (f[0])
            begin
                // step pending while stopped: release the core
                f = f & ~(dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET);
            end
            else if (ended)
            begin
                f2 = (f & ~step_bit) | dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET;
                if ((f2 & dbsu_pkg::STS_STEPS) != '0)
                    f = f2 & ~(dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET);
                else
                begin
                    f      = f2;
                    halt_v = 1'b1;
                end
            end
        end

        if (act_reg != dbsu_pkg::ACT_READ_STATUS)
            shown = f;
        status_next = f;
    end

    // ---------------- memory port control ----------------
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = cnt_reg[IDX_W-1:0];
        wr_data = '{pc: pc_reg, method: mid_reg};
        if (state_reg == dbsu_pkg::ST_MV_WR)
        begin
            wr_en   = 1'b1;
            wr_addr = hit_idx_reg;
            wr_data = rd_reg;
        end
        else if (commit && act_reg == dbsu_pkg::ACT_ADD && cnt_reg < CNT_MAX && !hit_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_reg <= mem[rd_addr];
    end

    // ---------------- output register ----------------
    always_comb
    begin
        if (commit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dbsu_pkg::ST_IDLE;
            status_reg    <= dbsu_pkg::STS_RESET;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            bound_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            if (commit)
            begin
                status_reg <= status_next;
                cnt_reg    <= cnt_next;
                if (load_bound)
                    bound_reg <= len_reg;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        hit_idx_reg <= hit_idx_next;
        if (accept)
        begin
            act_reg <= action;
            pc_reg  <= pc;
            mid_reg <= method_id;
            sp_reg  <= stack_ptr;
            len_reg <= step_length;
            en_reg  <= enable_bit;
            fv_reg  <= frame_valid;
        end
        if (commit)
        begin
            halt_reg    <= halt_v;
            resp_reg    <= resp_v;
            sts_out_reg <= shown;
            if (load_start)
            begin
                start_pc_reg  <= pc_reg;
                start_sp_reg  <= sp_reg;
                start_mid_reg <= mid_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign halt        = halt_reg;
    assign resp_code   = resp_reg;
    assign status_byte = sts_out_reg;

    // ---------------- assertions ----------------
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_MAX)
        else $error("breakpoint count above table size");

    a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(status_reg[4:2]))
        else $error("more than one step mode active");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != dbsu_pkg::ST_IDLE)
        else $error("sequencer did not start on accepted word");

    a_halt_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && halt) |-> resp_code == dbsu_pkg::RESP_OK)
        else $error("halt with non-ok response");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (state_reg == dbsu_pkg::ST_IDLE) && out_valid_reg)
        else $error("result load did not return to idle");

endmodule

FILE: bench/debug_breakpoint_step_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// debug_breakpoint_step_unit_tb
// Self-checking bench for the debug halt unit. An initial block fills a queue
// with directed and random words (instruction flow, rechecks, exceptions and
// debugger commands). A clocked driver feeds them to the unit, a clocked
// monitor predicts each reply from its own model of the breakpoint table,
// status byte and step start point, and checks every reply against it.
// ----------------------------------------------------------------------------
module debug_breakpoint_step_unit_tb;

    localparam int BKP_SLOTS    = 8;
    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 2 * BKP_SLOTS + 8;

    // codes outside the command set
    localparam logic [3:0] ACT_UNDEF_LO = 4'd14;
    localparam logic [3:0] ACT_UNDEF_HI = 4'd15;

    typedef struct {
        bit [3:0]    action;
        bit [31:0]   pc;
        bit [31:0]   method_id;
        bit [31:0]   stack_ptr;
        bit [31:0]   step_length;
        bit          enable_bit;
        bit          frame_valid;
        int unsigned gap;
        bit          drain;
    } cmd_word_t;

    typedef struct {
        bit       halt;
        bit [1:0] resp;
        bit [7:0] status;
        bit [3:0] action;
    } debug_reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [3:0]  action;
    logic [31:0] pc;
    logic [31:0] method_id;
    logic [31:0] stack_ptr;
    logic [31:0] step_length;
    logic        enable_bit;
    logic        frame_valid;
    logic        out_valid;
    logic        out_stall;
    logic        halt;
    logic [1:0]  resp_code;
    logic [7:0]  status_byte;

    debug_breakpoint_step_unit #(
        .MAX_BREAKPOINTS(BKP_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .action(action),
        .pc(pc),
        .method_id(method_id),
        .stack_ptr(stack_ptr),
        .step_length(step_length),
        .enable_bit(enable_bit),
        .frame_valid(frame_valid),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .halt(halt),
        .resp_code(resp_code),
        .status_byte(status_byte)
    );

    always #6 clk = ~clk;

    // ---------------- prediction state ----------------
    logic [31:0] bp_pc [BKP_SLOTS];
    logic [31:0] bp_method [BKP_SLOTS];
    int unsigned bp_count;
    logic [7:0]  dbg_status;
    logic [31:0] step_pc;
    logic [31:0] step_sp;
    logic [31:0] step_method;
    logic [31:0] step_limit;

    cmd_word_t    pending [$];
    debug_reply_t expected_replies [$];

    int words_sent;
    int words_accepted;
    int results_seen;
    int mismatches;
    int halts_seen;
    int bkp_hits;
    int steps_ended;
    int busy_replies;
    int fail_replies;
    int adds_refused;
    int pauses;
    int cycle_count;

    // stimulus context: current method, pc and stack pointer of the program
    logic [31:0] ctx_pc;
    logic [31:0] ctx_method;
    logic [31:0] ctx_sp;
    logic [31:0] win_pc;
    logic [31:0] win_sp;
    logic [31:0] method_pool [4];
    bit          tx_quiet;

    function automatic bit outside_step_window(input logic [31:0] w_pc, w_mid);
        logic [31:0] pc_offset;
        pc_offset = w_pc - step_pc;
        return (w_mid != step_method) || (pc_offset >= step_limit) || (w_pc <= step_pc);
    endfunction

    // pending steps are taken in the order in, over, out; an ended step turns
    // into a stop and the rule runs again
    function automatic bit resolve_halt(input logic [31:0] w_pc, w_mid, w_sp);
        logic [7:0] step_bit;
        bit         ended;
        for (int iter = 0; iter < 4; iter++)
        begin
            if ((dbg_status & dbsu_pkg::STS_STEP_IN) != 0)
            begin
                step_bit = dbsu_pkg::STS_STEP_IN;
                ended = outside_step_window(w_pc, w_mid);
            end
            else if ((dbg_status & dbsu_pkg::STS_STEP_OV) != 0)
            begin
                step_bit = dbsu_pkg::STS_STEP_OV;
                ended = (w_sp <= step_sp) && outside_step_window(w_pc, w_mid);
            end
            else if ((dbg_status & dbsu_pkg::STS_STEP_OUT) != 0)
            begin
                step_bit = dbsu_pkg::STS_STEP_OUT;
                ended = w_sp < step_sp;
            end
            else
            begin
                return (dbg_status & (dbsu_pkg::STS_STOP | dbsu_pkg::STS_EXCP)) != 0;
            end
            // step issued while stopped: release the core first
            if ((dbg_status & dbsu_pkg::STS_STOP) != 0)
            begin
                dbg_status &= ~(dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET);
                return 1'b0;
            end
            if (!ended)
                return 1'b0;
            dbg_status = (dbg_status & ~step_bit) | dbsu_pkg::STS_STOP
                         | dbsu_pkg::STS_STOP_SET;
            steps_ended++;
        end
        return (dbg_status & (dbsu_pkg::STS_STOP | dbsu_pkg::STS_EXCP)) != 0;
    endfunction

    function automatic void check_breakpoints(input logic [31:0] w_pc, w_mid);
        bit hit;
        hit = 1'b0;
        if ((dbg_status & dbsu_pkg::STS_STOP) != 0)
            return;
        for (int i = 0; i < bp_count && !hit; i++)
            if (bp_method[i] == w_mid && bp_pc[i] == w_pc)
                hit = 1'b1;
        if (hit)
        begin
            dbg_status |= dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET;
            bkp_hits++;
        end
    endfunction

    function automatic debug_reply_t predict_reply(input cmd_word_t w);
        debug_reply_t r;
        logic [7:0]   shown;
        logic [7:0]   step_bit;
        bit           shown_valid;
        bit           hit;
        r.halt = 1'b0;
        r.resp = dbsu_pkg::RESP_OK;
        r.action = w.action;
        shown = 8'h00;
        shown_valid = 1'b0;
        hit = 1'b0;
        case (w.action)
            dbsu_pkg::ACT_EXEC:
            begin
                check_breakpoints(w.pc, w.method_id);
                r.halt = resolve_halt(w.pc, w.method_id, w.stack_ptr);
            end
            dbsu_pkg::ACT_RECHECK:
                r.halt = resolve_halt(w.pc, w.method_id, w.stack_ptr);
            dbsu_pkg::ACT_RUN:
                dbg_status &= ~(dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET
                                | dbsu_pkg::STS_STEPS | dbsu_pkg::STS_EXCP);
            dbsu_pkg::ACT_STOP:
                dbg_status = (dbg_status & ~(dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_STEPS
                                             | dbsu_pkg::STS_EXCP)) | dbsu_pkg::STS_STOP;
            dbsu_pkg::ACT_STEP_IN, dbsu_pkg::ACT_STEP_OVER, dbsu_pkg::ACT_STEP_OUT:
            begin
                if ((dbg_status & dbsu_pkg::STS_STOP) == 0
                    || (w.action != dbsu_pkg::ACT_STEP_OUT && w.step_length == 0))
                    r.resp = dbsu_pkg::RESP_BUSY;
                else if (!w.frame_valid)
                    r.resp = dbsu_pkg::RESP_FAIL;
                else
                begin
                    step_bit = (w.action == dbsu_pkg::ACT_STEP_IN) ? dbsu_pkg::STS_STEP_IN :
                               (w.action == dbsu_pkg::ACT_STEP_OVER) ? dbsu_pkg::STS_STEP_OV :
                               dbsu_pkg::STS_STEP_OUT;
                    step_pc = w.pc;
                    step_method = w.method_id;
                    step_sp = w.stack_ptr;
                    if (w.action != dbsu_pkg::ACT_STEP_OUT)
                        step_limit = w.step_length;
                    dbg_status = (dbg_status & ~(dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_STEPS
                                                 | dbsu_pkg::STS_EXCP)) | step_bit;
                end
            end
            dbsu_pkg::ACT_ADD:
            begin
                if (bp_count < BKP_SLOTS)
                begin
                    for (int i = 0; i < bp_count; i++)
                        if (bp_method[i] == w.method_id && bp_pc[i] == w.pc)
                            hit = 1'b1;
                    if (!hit)
                    begin
                        bp_pc[bp_count] = w.pc;
                        bp_method[bp_count] = w.method_id;
                        bp_count++;
                    end
                end
                else
                begin
                    r.resp = dbsu_pkg::RESP_FAIL;
                    adds_refused++;
                end
            end
            dbsu_pkg::ACT_REMOVE:
            begin
                if (bp_count == 0)
                    r.resp = dbsu_pkg::RESP_FAIL;
                else
                begin
                    // a match is overwritten by the last entry
                    for (int i = 0; i < bp_count && !hit; i++)
                        if (bp_method[i] == w.method_id && bp_pc[i] == w.pc)
                        begin
                            bp_pc[i] = bp_pc[bp_count - 1];
                            bp_method[i] = bp_method[bp_count - 1];
                            bp_count--;
                            hit = 1'b1;
                        end
                end
            end
            dbsu_pkg::ACT_CLEAR:
                bp_count = 0;
            dbsu_pkg::ACT_EXCP_MODE:
                if (w.enable_bit)
                    dbg_status |= dbsu_pkg::STS_EXCP_EN;
                else
                    dbg_status &= ~dbsu_pkg::STS_EXCP_EN;
            dbsu_pkg::ACT_EXCEPTION:
            begin
                dbg_status &= ~dbsu_pkg::STS_STEPS;
                dbg_status |= dbsu_pkg::STS_STOP | dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_EXCP;
                check_breakpoints(w.pc, w.method_id);
                r.halt = resolve_halt(w.pc, w.method_id, w.stack_ptr);
            end
            dbsu_pkg::ACT_READ_STATUS:
            begin
                // stop bits are hidden while a step is pending; a reported
                // stop_set is consumed by the read
                shown = dbg_status;
                if ((shown & dbsu_pkg::STS_STEPS) != 0)
                    shown &= ~(dbsu_pkg::STS_STOP_SET | dbsu_pkg::STS_STOP);
                if ((shown & dbsu_pkg::STS_STOP_SET) != 0)
                    dbg_status &= ~dbsu_pkg::STS_STOP_SET;
                shown_valid = 1'b1;
            end
            dbsu_pkg::ACT_DONE:
                dbg_status |= dbsu_pkg::STS_DONE;
            default:
                r.resp = dbsu_pkg::RESP_FAIL;
        endcase
        r.status = shown_valid ? shown : dbg_status;
        if (r.resp == dbsu_pkg::RESP_BUSY)
            busy_replies++;
        if (r.resp == dbsu_pkg::RESP_FAIL)
            fail_replies++;
        return r;
    endfunction

    // ---------------- stimulus helpers ----------------
    function automatic void queue_word(input logic [3:0] act,
                                       input logic [31:0] w_pc, w_mid, w_sp, w_len,
                                       input bit w_en, w_fv);
        cmd_word_t w;
        w.action = act;
        w.pc = w_pc;
        w.method_id = w_mid;
        w.stack_ptr = w_sp;
        w.step_length = w_len;
        w.enable_bit = w_en;
        w.frame_valid = w_fv;
        w.gap = tx_quiet ? 0 : $urandom_range(0, 15);
        w.drain = 1'b0;
        pending.push_back(w);
    endfunction

    function automatic void queue_pause();
        cmd_word_t w;
        w = '{default: 0};
        w.drain = 1'b1;
        pending.push_back(w);
    endfunction

    function automatic bit coin();
        return bit'($urandom_range(0, 1));
    endfunction

    function automatic logic [31:0] pick_method();
        return method_pool[$urandom_range(0, 3)];
    endfunction

    function automatic logic [31:0] pick_bkp_pc();
        return win_pc + $urandom_range(0, 11);
    endfunction

    function automatic logic [31:0] pick_step_length();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 7)
            return $urandom_range(1, 24);
        if (roll == 7)
            return 32'h0;
        if (roll == 8)
            return $urandom;
        return 32'hFFFF_FFFF;
    endfunction

    // next instruction of the running program: mostly short forward moves,
    // sometimes a jump back into the window or a method change
    function automatic void advance_context();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            ctx_method = pick_method();
        if (roll < 15)
            ctx_pc = win_pc + $urandom_range(0, 23);
        else
            ctx_pc = ctx_pc + $urandom_range(0, 3);
        ctx_sp = win_sp + $urandom_range(0, 15);
    endfunction

    // ---------------- driver ----------------
    cmd_word_t   next_w;
    int unsigned gap_left;
    int unsigned cur_gap;

    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (in_valid)
            begin
                words_sent++;
                gap_left = cur_gap;
            end
            if (gap_left != 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending.size() != 0 && pending[0].drain)
            begin
                // hold off until every reply is back
                if (words_sent == results_seen)
                begin
                    pending.delete(0);
                    pauses++;
                end
                in_valid <= 1'b0;
            end
            else if (pending.size() != 0)
            begin
                next_w = pending.pop_front();
                action <= next_w.action;
                pc <= next_w.pc;
                method_id <= next_w.method_id;
                stack_ptr <= next_w.stack_ptr;
                step_length <= next_w.step_length;
                enable_bit <= next_w.enable_bit;
                frame_valid <= next_w.frame_valid;
                cur_gap = next_w.gap;
                in_valid <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ---------------- receiver stalls ----------------
    int unsigned rx_left;
    int unsigned rx_count;
    bit          rx_quiet;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                rx_count++;
                if (rx_count % 64 == 0)
                    rx_quiet = ($urandom_range(0, 3) == 0);
                rx_left = rx_quiet ? 0 : $urandom_range(0, 15);
                out_stall <= (rx_left != 0);
            end
            else if (rx_left != 0)
            begin
                rx_left--;
                out_stall <= (rx_left != 0);
            end
        end
    end

    // ---------------- monitor ----------------
    cmd_word_t    seen_w;
    debug_reply_t want;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // replies first: a reply can never belong to the word taken now
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (halt === 1'b1)
                    halts_seen++;
                if (expected_replies.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] reply with none pending: halt=%b resp=%0d status=%02h",
                                 $realtime, halt, resp_code, status_byte);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (halt !== want.halt || resp_code !== want.resp
                        || status_byte !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("[%0t] action %0d: expected halt=%b resp=%0d status=%02h",
                                     $realtime, want.action, want.halt, want.resp,
                                     want.status);
                            $display("    got halt=%b resp=%0d status=%02h",
                                     halt, resp_code, status_byte);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                seen_w.action = action;
                seen_w.pc = pc;
                seen_w.method_id = method_id;
                seen_w.stack_ptr = stack_ptr;
                seen_w.step_length = step_length;
                seen_w.enable_bit = enable_bit;
                seen_w.frame_valid = frame_valid;
                seen_w.gap = 0;
                seen_w.drain = 1'b0;
                expected_replies.push_back(predict_reply(seen_w));
                words_accepted++;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies still pending",
                     cycle_count, expected_replies.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial
    begin
        int unsigned roll;

        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = dbsu_pkg::ACT_EXEC;
        pc = 32'h0;
        method_id = 32'h0;
        stack_ptr = 32'h0;
        step_length = 32'h0;
        enable_bit = 1'b0;
        frame_valid = 1'b0;
        gap_left = 0;
        cur_gap = 0;
        rx_left = 0;

        for (int i = 0; i < BKP_SLOTS; i++)
        begin
            bp_pc[i] = 32'h0;
            bp_method[i] = 32'h0;
        end
        bp_count = 0;
        dbg_status = dbsu_pkg::STS_RESET;
        step_pc = 32'h0;
        step_sp = 32'h0;
        step_method = 32'h0;
        step_limit = 32'h0;

        // directed words
        tx_quiet = 1'b0;
        queue_word(dbsu_pkg::ACT_READ_STATUS, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_STEP_IN, 32'h100, 32'h5, 32'h80, 32'h0, 1'b0, 1'b1);
        queue_word(dbsu_pkg::ACT_STEP_OUT, 32'h100, 32'h5, 32'h80, 32'hFFFF_FFFF,
                   1'b1, 1'b0);
        queue_word(dbsu_pkg::ACT_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 1'b1, 1'b1);
        queue_word(dbsu_pkg::ACT_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_ADD, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_RUN, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h0, 32'h0, 32'h40, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_READ_STATUS, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_STEP_IN, 32'h100, 32'h5, 32'h80, 32'h10, 1'b0, 1'b1);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h104, 32'h5, 32'h80, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h110, 32'h5, 32'h80, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_STEP_OVER, 32'h200, 32'h7, 32'h100, 32'h8, 1'b0, 1'b1);
        queue_word(dbsu_pkg::ACT_RECHECK, 32'h200, 32'h7, 32'h100, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h300, 32'h7, 32'h140, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h300, 32'h7, 32'h100, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_STEP_OUT, 32'h300, 32'h7, 32'h100, 32'h0, 1'b0, 1'b1);
        queue_word(dbsu_pkg::ACT_RECHECK, 32'h300, 32'h7, 32'h100, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXEC, 32'h40, 32'h9, 32'hFF, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_EXCP_MODE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0);
        queue_word(dbsu_pkg::ACT_EXCEPTION, 32'h44, 32'h9, 32'hF0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0,
                   1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_CLEAR, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(dbsu_pkg::ACT_REMOVE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_word(ACT_UNDEF_HI, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0);
        queue_pause();

        // random words: mostly a program running against breakpoints set in
        // its own code window, with debugger commands mixed in
        method_pool[2] = 32'hFFFF_FFFF;
        method_pool[3] = 32'h0;
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n % 150 == 0)
            begin
                roll = $urandom_range(0, 9);
                win_pc = (roll < 3) ? 32'hFFFF_FFF0 + $urandom_range(0, 8) :
                         (roll == 3) ? 32'h0 : $urandom;
                roll = $urandom_range(0, 9);
                win_sp = (roll < 2) ? 32'hFFFF_FFF0 : (roll == 2) ? 32'h0 : $urandom;
                method_pool[0] = $urandom;
                method_pool[1] = $urandom & 32'hFF;
                ctx_method = pick_method();
                ctx_pc = win_pc;
                ctx_sp = win_sp;
            end
            if (n % 80 == 0)
                tx_quiet = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399)
                queue_pause();
            // occasional burst that fills the table and runs past it
            if ($urandom_range(0, 99) < 2)
                repeat (9) queue_word(dbsu_pkg::ACT_ADD, pick_bkp_pc(), pick_method(),
                                      $urandom, $urandom, coin(), coin());

            roll = $urandom_range(0, 99);
            if (roll < 6)
                queue_word(4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, $urandom,
                           coin(), coin());
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 38)
                begin
                    advance_context();
                    queue_word(dbsu_pkg::ACT_EXEC, ctx_pc, ctx_method, ctx_sp, $urandom,
                               coin(), coin());
                end
                else if (roll < 46)
                    queue_word(dbsu_pkg::ACT_RECHECK, ctx_pc, ctx_method, ctx_sp, $urandom,
                               coin(), coin());
                else if (roll < 52)
                    queue_word(dbsu_pkg::ACT_RUN, $urandom, $urandom, $urandom, $urandom,
                               coin(), coin());
                else if (roll < 55)
                    queue_word(dbsu_pkg::ACT_STOP, $urandom, $urandom, $urandom, $urandom,
                               coin(), coin());
                else if (roll < 61)
                    queue_word(dbsu_pkg::ACT_STEP_IN, ctx_pc, ctx_method, ctx_sp,
                               pick_step_length(), coin(), $urandom_range(0, 9) != 0);
                else if (roll < 67)
                    queue_word(dbsu_pkg::ACT_STEP_OVER, ctx_pc, ctx_method, ctx_sp,
                               pick_step_length(), coin(), $urandom_range(0, 9) != 0);
                else if (roll < 72)
                    queue_word(dbsu_pkg::ACT_STEP_OUT, ctx_pc, ctx_method, ctx_sp,
                               pick_step_length(), coin(), $urandom_range(0, 9) != 0);
                else if (roll < 80)
                    queue_word(dbsu_pkg::ACT_ADD, pick_bkp_pc(), pick_method(), $urandom,
                               $urandom, coin(), coin());
                else if (roll < 85)
                    queue_word(dbsu_pkg::ACT_REMOVE, pick_bkp_pc(), pick_method(), $urandom,
                               $urandom, coin(), coin());
                else if (roll < 86)
                    queue_word(dbsu_pkg::ACT_CLEAR, $urandom, $urandom, $urandom, $urandom,
                               coin(), coin());
                else if (roll < 88)
                    queue_word(dbsu_pkg::ACT_EXCP_MODE, $urandom, $urandom, $urandom,
                               $urandom, coin(), coin());
                else if (roll < 90)
                begin
                    advance_context();
                    queue_word(dbsu_pkg::ACT_EXCEPTION, ctx_pc, ctx_method, ctx_sp,
                               $urandom, coin(), coin());
                end
                else if (roll < 96)
                    queue_word(dbsu_pkg::ACT_READ_STATUS, $urandom, $urandom, $urandom,
                               $urandom, coin(), coin());
                else if (roll < 97)
                    queue_word(dbsu_pkg::ACT_DONE, $urandom, $urandom, $urandom, $urandom,
                               coin(), coin());
                else
                    queue_word(coin() ? ACT_UNDEF_HI : ACT_UNDEF_LO,
                               $urandom, $urandom, $urandom, $urandom, coin(), coin());
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending.size() != 0 || in_valid)
            @(negedge clk);
        while (expected_replies.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (expected_replies.size() != 0)
        begin
            $display("%0d replies never arrived", expected_replies.size());
            mismatches += expected_replies.size();
        end

        $display("Covered %0d words, %0d replies, %0d halts, %0d bkp hits, %0d steps ended",
                 words_accepted, results_seen, halts_seen, bkp_hits, steps_ended);
        $display("Replies: %0d busy, %0d fail, %0d full adds, %0d drains, %0d mismatches",
                 busy_replies, fail_replies, adds_refused, pauses, mismatches);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
